// ===== hdl/jms_pkg.sv =====
// Package for the JPEG marker scanner: item types, marker codes and the
// record passed from the classifier to the result sequencer. No dependencies.
package jms_pkg;

  // Result kinds reported on event_kind
  typedef enum logic [3:0] {
    KIND_SOI     = 4'd0,
    KIND_APP0    = 4'd1,
    KIND_DQT     = 4'd2,
    KIND_SOF0    = 4'd3,
    KIND_DHT     = 4'd4,
    KIND_SOS     = 4'd5,
    KIND_EOI     = 4'd6,
    KIND_HEADER  = 4'd7,
    KIND_VERDICT = 4'd8
  } event_kind_e;

  // Marker code bytes that follow a 0xFF
  localparam logic [7:0] MRK_PREFIX = 8'hFF;
  localparam logic [7:0] MRK_SOI    = 8'hD8;
  localparam logic [7:0] MRK_APP0   = 8'hE0;
  localparam logic [7:0] MRK_DQT    = 8'hDB;
  localparam logic [7:0] MRK_SOF0   = 8'hC0;
  localparam logic [7:0] MRK_DHT    = 8'hC4;
  localparam logic [7:0] MRK_SOS    = 8'hDA;
  localparam logic [7:0] MRK_EOI    = 8'hD9;

  // Indexes of the per-kind slot lists
  localparam logic [1:0] LIST_DQT  = 2'd0;
  localparam logic [1:0] LIST_SOF0 = 2'd1;
  localparam logic [1:0] LIST_DHT  = 2'd2;
  localparam logic [1:0] LIST_SOS  = 2'd3;
  localparam int         NUM_LISTS = 4;

  // Offsets from the first SOF0's 0xFF that carry the frame header
  localparam logic [3:0] HDR_HEIGHT_HI = 4'd5;
  localparam logic [3:0] HDR_HEIGHT_LO = 4'd6;
  localparam logic [3:0] HDR_WIDTH_HI  = 4'd7;
  localparam logic [3:0] HDR_WIDTH_LO  = 4'd8;
  localparam logic [3:0] HDR_COMP      = 4'd9;

  // Depth of the queue between classifier and sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [23:0] marker_position;
    logic [3:0]  list_slot;
    logic        slot_overflow;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [7:0]  component_count;
    logic        is_jpeg;
    logic        last_of_run;
  } result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic        has_marker;
    event_kind_e marker_kind;
    logic [23:0] marker_position;
    logic [3:0]  list_slot;
    logic        slot_overflow;
    logic        has_header;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [7:0]  component_count;
    logic        has_verdict;
    logic        is_jpeg;
  } run_t;

endpackage

// ===== hdl/jpeg_marker_scanner.sv =====
// JPEG marker scanner, top level. A result passes through the run queue, the
// unpack register and the output register before it shows on the result port.
// Throughput: one byte per cycle while each byte causes at most one result and
// the result port is popped; a byte with two or three results holds the result
// port for each in turn, and the 4-entry run queue absorbs short bursts of them.
// Reset: asynchronous, active low; clears all scan state, run queue and output.
module jpeg_marker_scanner #(
  parameter int POSITION_BITS = 24,
  parameter int LIST_DEPTH    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jms_pkg::byte_item_t in_item_i,
  input  logic               push,
  output logic               full,
  output jms_pkg::result_t   out_item_o,
  output logic               empty,
  input  logic               pop
);
  import jms_pkg::*;

  logic accept;
  logic run_valid, run_pop, run_empty;
  run_t run_in, run_out;

  assign accept = push && !full;

  jms_front #(
    .POSITION_BITS(POSITION_BITS),
    .LIST_DEPTH   (LIST_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .run_valid_o(run_valid),
    .run_o      (run_in)
  );

  jms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (run_valid),
    .wdata_i(run_in),
    .full_o (full),
    .pop_i  (run_pop),
    .rdata_o(run_out),
    .empty_o(run_empty)
  );

  jms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .run_i      (run_out),
    .run_empty_i(run_empty),
    .run_pop_o  (run_pop),
    .result_o   (out_item_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

// ===== hdl/jms_front.sv =====
// Classifier: decodes markers, tracks position, slot lists, frame header and
// start/end check; builds one run record per byte with results. Depends on jms_pkg.
module jms_front #(
  parameter int POSITION_BITS = 24,
  parameter int LIST_DEPTH    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  jms_pkg::byte_item_t item_i,
  output logic               run_valid_o,
  output jms_pkg::run_t      run_o
);
  import jms_pkg::*;

  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam logic [POSITION_BITS-1:0] PosTop = {POSITION_BITS{1'b1}};
  localparam logic [CntW-1:0] CntFull = CntW'(LIST_DEPTH);

  logic                     prev_ff_q, prev_ff_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CntW-1:0]          cnt_q [NUM_LISTS];
  logic [CntW-1:0]          cnt_d [NUM_LISTS];
  logic                     sof_q, sof_d;
  logic [3:0]               hoff_q, hoff_d;
  logic [15:0]              height_q, height_d;
  logic [15:0]              width_q, width_d;
  logic                     start_ok_q, start_ok_d;

  logic [7:0]               b;
  logic                     fin;
  logic                     hit;
  logic                     in_list;
  logic [1:0]               list_idx;
  event_kind_e              kind;
  logic [3:0]               hoff_next;
  logic                     hdr_emit;
  logic [POSITION_BITS-1:0] mpos;
  logic [POSITION_BITS+23:0] mpos_ext;
  logic [CntW-1:0]          cnt_sel;
  logic [CntW+3:0]          slot_ext;
  logic [3:0]               slot;
  logic                     ovf;
  run_t                     run;

  assign b   = item_i.data_byte;
  assign fin = item_i.final_byte;

  // Decode the marker code byte
  always_comb begin
    hit      = 1'b0;
    in_list  = 1'b0;
    list_idx = LIST_DQT;
    kind     = KIND_SOI;
    case (b)
      MRK_SOI: begin
        hit = 1'b1; kind = KIND_SOI;
      end
      MRK_APP0: begin
        hit = 1'b1; kind = KIND_APP0;
      end
      MRK_DQT: begin
        hit = 1'b1; kind = KIND_DQT; in_list = 1'b1; list_idx = LIST_DQT;
      end
      MRK_SOF0: begin
        hit = 1'b1; kind = KIND_SOF0; in_list = 1'b1; list_idx = LIST_SOF0;
      end
      MRK_DHT: begin
        hit = 1'b1; kind = KIND_DHT; in_list = 1'b1; list_idx = LIST_DHT;
      end
      MRK_SOS: begin
        hit = 1'b1; kind = KIND_SOS; in_list = 1'b1; list_idx = LIST_SOS;
      end
      MRK_EOI: begin
        hit = 1'b1; kind = KIND_EOI;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    hit = hit & prev_ff_q;
  end

  // Position of the 0xFF that opened the marker
  always_comb begin
    if (pos_q == PosTop) begin
      mpos = PosTop;
    end else if (pos_q == '0) begin
      mpos = '0;
    end else begin
      mpos = pos_q - 1'b1;
    end
  end
  assign mpos_ext = {24'd0, mpos};

  // Slot lookup in the selected list
  assign cnt_sel  = cnt_q[list_idx];
  assign ovf      = in_list && (cnt_sel >= CntFull);
  assign slot_ext = {4'd0, cnt_sel};
  assign slot     = (in_list && !ovf) ? slot_ext[3:0] : 4'd0;

  assign hoff_next = hoff_q + 4'd1;
  assign hdr_emit  = (hoff_q != 4'd0) && (hoff_next == HDR_COMP);

  // Next state
  always_comb begin
    prev_ff_d  = prev_ff_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    sof_d      = sof_q;
    hoff_d     = hoff_q;
    height_d   = height_q;
    width_d    = width_q;
    start_ok_d = start_ok_q;
    if (accept_i) begin
      // capture the frame header fields
      if (hoff_q != 4'd0) begin
        case (hoff_next)
          HDR_HEIGHT_HI: height_d = {b, 8'd0};
          HDR_HEIGHT_LO: height_d = {height_q[15:8], b};
          HDR_WIDTH_HI:  width_d  = {b, 8'd0};
          HDR_WIDTH_LO:  width_d  = {width_q[15:8], b};
          default:       height_d = height_q;
        endcase
        hoff_d = hdr_emit ? 4'd0 : hoff_next;
      end
      // advance the slot list
      if (hit && in_list) begin
        cnt_d[list_idx] = ovf ? CntFull : cnt_sel + 1'b1;
      end
      if (hit && (kind == KIND_SOF0) && !sof_q) begin
        sof_d  = 1'b1;
        hoff_d = 4'd1;
      end
      if ((pos_q == POSITION_BITS'(1)) && prev_ff_q && (b == MRK_SOI)) begin
        start_ok_d = 1'b1;
      end
      if (fin) begin
        // drop all state: the next byte opens a new file
        prev_ff_d  = 1'b0;
        pos_d      = '0;
        for (int i = 0; i < NUM_LISTS; i++) cnt_d[i] = '0;
        sof_d      = 1'b0;
        hoff_d     = 4'd0;
        height_d   = 16'd0;
        width_d    = 16'd0;
        start_ok_d = 1'b0;
      end else begin
        prev_ff_d = (b == MRK_PREFIX);
        if (pos_q != PosTop) pos_d = pos_q + 1'b1;
      end
    end
  end

  // Build the run record
  always_comb begin
    run.has_marker      = hit;
    run.marker_kind     = kind;
    run.marker_position = mpos_ext[23:0];
    run.list_slot       = slot;
    run.slot_overflow   = ovf;
    run.has_header      = hdr_emit;
    run.image_height    = height_q;
    run.image_width     = width_q;
    run.component_count = b;
    run.has_verdict     = fin;
    run.is_jpeg         = start_ok_q && prev_ff_q && (b == MRK_EOI);
  end

  assign run_o       = run;
  assign run_valid_o = accept_i && (hit || hdr_emit || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ff_q  <= 1'b0;
      pos_q      <= '0;
      for (int i = 0; i < NUM_LISTS; i++) cnt_q[i] <= '0;
      sof_q      <= 1'b0;
      hoff_q     <= 4'd0;
      height_q   <= 16'd0;
      width_q    <= 16'd0;
      start_ok_q <= 1'b0;
    end else begin
      prev_ff_q  <= prev_ff_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      sof_q      <= sof_d;
      hoff_q     <= hoff_d;
      height_q   <= height_d;
      width_q    <= width_d;
      start_ok_q <= start_ok_d;
    end
  end

endmodule

// ===== hdl/jms_queue.sv =====
// Short queue of run records between classifier and sequencer.
// Depends on jms_pkg.
module jms_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jms_pkg::run_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output jms_pkg::run_t rdata_o,
  output logic          empty_o
);
  import jms_pkg::*;

  run_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  // Store the record
  always_ff @(posedge clk_i) begin
    if (do_push) mem[wptr_q] <= wdata_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/jms_back.sv =====
// Result sequencer: unpacks each run record into marker, header and verdict
// items and holds the oldest one in the output register. Depends on jms_pkg.
module jms_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jms_pkg::run_t    run_i,
  input  logic             run_empty_i,
  output logic             run_pop_o,
  output jms_pkg::result_t result_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import jms_pkg::*;

  run_t    cur_q, cur_d;
  logic    [2:0] pend_q, pend_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  logic    adv;
  logic    [2:0] sel;
  logic    [2:0] left;
  result_t res;

  assign adv = !out_valid_q || pop_i;

  // Pick the next pending result: marker, then header, then verdict
  always_comb begin
    if (pend_q[0]) begin
      sel = 3'b001;
    end else if (pend_q[1]) begin
      sel = 3'b010;
    end else begin
      sel = pend_q & 3'b100;
    end
    left = pend_q & ~sel;
  end

  always_comb begin
    res = '0;
    res.last_of_run = (left == 3'b000);
    if (sel[0]) begin
      res.event_kind      = cur_q.marker_kind;
      res.marker_position = cur_q.marker_position;
      res.list_slot       = cur_q.list_slot;
      res.slot_overflow   = cur_q.slot_overflow;
    end else if (sel[1]) begin
      res.event_kind      = KIND_HEADER;
      res.image_height    = cur_q.image_height;
      res.image_width     = cur_q.image_width;
      res.component_count = cur_q.component_count;
    end else begin
      res.event_kind = KIND_VERDICT;
      res.is_jpeg    = cur_q.is_jpeg;
    end
  end

  // Advance the output register and reload the current run
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    cur_d       = cur_q;
    run_pop_o   = 1'b0;
    if (adv) begin
      out_valid_d = (pend_q != 3'b000);
      out_d       = res;
      pend_d      = left;
    end
    if ((pend_d == 3'b000) && !run_empty_i) begin
      run_pop_o = 1'b1;
      cur_d     = run_i;
      pend_d    = {run_i.has_verdict, run_i.has_header, run_i.has_marker};
    end
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
